>>> src/mvbh_pkg.sv
// ----------------------------------------------------------------------------
// mvbh_pkg: shared constants and types for the value and byte-string hasher
// Mixing constants, sequencer states and small helper functions.
// ----------------------------------------------------------------------------
package mvbh_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned LEN_W   = 32;
   localparam int unsigned HALF_W  = WORD_W / 2;
   localparam int unsigned TDATA_W = WORD_W + LEN_W;
   localparam int unsigned TUSER_W = 3;

   // tuser bit positions
   localparam int unsigned USER_OPCODE  = 0;
   localparam int unsigned USER_RESTART = 1;
   localparam int unsigned USER_FIRST   = 2;

   // opcode values
   localparam logic OP_VALUE  = 1'b0;
   localparam logic OP_STRING = 1'b1;

   // fmix64 finalizer
   localparam logic [WORD_W-1:0] FX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [WORD_W-1:0] FX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [5:0]        FX_S  = 6'd33;

   // MurmurHash64A
   localparam logic [WORD_W-1:0] MH_M    = 64'hc6a4a7935bd1e995;
   localparam logic [WORD_W-1:0] MH_SEED = 64'h00000000e17a1465;
   localparam logic [5:0]        MH_R    = 6'd47;

   // multiplier phases: lo*lo, lo*hi, hi*lo
   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_MID   = 2'd1;
   localparam logic [1:0] PH_LAST  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FX1,       // x * C1
      ST_FX2,       // x * C2, then emit
      ST_SLEN,      // len * M
      ST_DISPATCH,  // choose block / tail / finalize
      ST_MB1,       // k * M
      ST_MB2,       // k * M
      ST_MB3,       // (h ^ k) * M
      ST_TAIL,      // (h ^ tail) * M
      ST_FIN        // final * M, then emit
   } state_type;

   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v,
                                                   input logic [5:0] s);
      return v ^ (v >> s);
   endfunction

   function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] t);
      return (64'd1 << {t, 3'b000}) - 64'd1;
   endfunction

endpackage

>>> src/murmur_value_and_bytes_hasher.sv
// Sequence: a fixed value runs through ST_FX1 and ST_FX2 and is emitted from
//   ST_FX2; a string word runs through ST_SLEN on a first word (length
//   multiply), ST_DISPATCH, ST_MB1..ST_MB3 or ST_TAIL as needed, and ST_FIN on a last word.
// Throughput: one beat at a time; every 64-bit multiply is three passes
//   through one 32x32 multiplier, and ST_FX2 or ST_FIN waits while the output is full.
// Reset: synchronous, active high; clears seed and running hash to zero.
// ----------------------------------------------------------------------------
// murmur_value_and_bytes_hasher: running record hash
// fmix64 of fixed values and MurmurHash64A of byte strings, XORed into a
// running hash, all on one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module murmur_value_and_bytes_hasher (
   input  logic                             clock,
   input  logic                             reset,
   // config
   input  logic                             csr_we,
   input  logic [mvbh_pkg::WORD_W-1:0]      csr_wdata,   // seed_value
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mvbh_pkg::TDATA_W-1:0]     req_tdata,   // data_word, byte_length
   input  logic [mvbh_pkg::TUSER_W-1:0]     req_tuser,   // opcode, restart, first_word
   input  logic                             req_tlast,   // last_word
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mvbh_pkg::WORD_W-1:0]      rsp_tdata    // hash_out
);
   import mvbh_pkg::*;

   state_type           state_ff, state_in;
   logic [1:0]          ph_ff, ph_in;
   logic [WORD_W-1:0]   seed_ff, seed_in;
   logic [WORD_W-1:0]   run_ff, run_in;     // running hash
   logic [WORD_W-1:0]   hash_ff, hash_in;   // string hash
   logic [LEN_W-1:0]    len_ff, len_in;     // stored length
   logic [WORD_W-1:0]   data_ff, data_in;   // beat data word
   logic                last_ff, last_in;
   logic [WORD_W-1:0]   x_ff, x_in;         // multiplier operand
   logic [WORD_W-1:0]   acc_ff, acc_in;     // partial product sum
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                out_free;
   logic                mul_done;
   logic [WORD_W-1:0]   mul_const;
   logic [HALF_W-1:0]   mul_a, mul_b;
   logic [WORD_W-1:0]   prod;
   logic [WORD_W-1:0]   acc_sum;
   logic [WORD_W-1:0]   fin_val;
   logic [2:0]          tail;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- shared multiplier: low 64 bits of x * const in three passes ----
   always_comb begin
      case (state_ff)
         ST_FX1:  mul_const = FX_C1;
         ST_FX2:  mul_const = FX_C2;
         default: mul_const = MH_M;
      endcase
   end

   assign mul_a    = (ph_ff == PH_LAST) ? x_ff[WORD_W-1:HALF_W] : x_ff[HALF_W-1:0];
   assign mul_b    = (ph_ff == PH_MID) ? mul_const[WORD_W-1:HALF_W] : mul_const[HALF_W-1:0];
   assign prod     = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   // cross terms only reach the upper half
   assign acc_sum  = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
   assign mul_done = (ph_ff == PH_LAST);
   assign fin_val  = xorshift(acc_sum, MH_R);
   assign tail     = len_ff[2:0];

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      seed_in      = csr_we ? csr_wdata : seed_ff;
      run_in       = run_ff;
      hash_in      = hash_ff;
      len_in       = len_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // phase stepping inside a multiply state; the done step is handled below
      if (state_ff != ST_IDLE && state_ff != ST_DISPATCH && !mul_done) begin
         ph_in  = ph_ff + 2'd1;
         acc_in = (ph_ff == PH_FIRST) ? prod : acc_sum;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in = req_tdata[WORD_W-1:0];
               last_in = req_tlast;
               ph_in   = PH_FIRST;
               if (req_tuser[USER_RESTART])
                  run_in = seed_ff;
               if (req_tuser[USER_OPCODE] == OP_VALUE) begin
                  x_in     = xorshift(req_tdata[WORD_W-1:0], FX_S);
                  state_in = ST_FX1;
               end else if (req_tuser[USER_FIRST]) begin
                  len_in   = req_tdata[TDATA_W-1:WORD_W];
                  x_in     = {{(WORD_W-LEN_W){1'b0}}, req_tdata[TDATA_W-1:WORD_W]};
                  state_in = ST_SLEN;
               end else begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_FX1: begin
            if (mul_done) begin
               x_in     = xorshift(acc_sum, FX_S);
               ph_in    = PH_FIRST;
               state_in = ST_FX2;
            end
         end
         ST_FX2: begin
            if (mul_done && out_free) begin
               run_in       = run_ff ^ xorshift(acc_sum, FX_S);
               rsp_data_in  = run_ff ^ xorshift(acc_sum, FX_S);
               rsp_valid_in = 1'b1;
               ph_in        = PH_FIRST;
               state_in     = ST_IDLE;
            end
         end
         ST_SLEN: begin
            if (mul_done) begin
               hash_in  = MH_SEED ^ acc_sum;
               ph_in    = PH_FIRST;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            ph_in = PH_FIRST;
            if (!last_ff) begin
               x_in     = data_ff;
               state_in = ST_MB1;
            end else if (tail != 3'd0) begin
               x_in     = hash_ff ^ (data_ff & tail_mask(tail));
               state_in = ST_TAIL;
            end else if (len_ff != '0) begin
               x_in     = data_ff;
               state_in = ST_MB1;
            end else begin
               // empty string: data ignored, finalize directly
               x_in     = xorshift(hash_ff, MH_R);
               state_in = ST_FIN;
            end
         end
         ST_MB1: begin
            if (mul_done) begin
               x_in     = xorshift(acc_sum, MH_R);
               ph_in    = PH_FIRST;
               state_in = ST_MB2;
            end
         end
         ST_MB2: begin
            if (mul_done) begin
               x_in     = hash_ff ^ acc_sum;
               ph_in    = PH_FIRST;
               state_in = ST_MB3;
            end
         end
         ST_MB3: begin
            if (mul_done) begin
               hash_in = acc_sum;
               ph_in   = PH_FIRST;
               if (last_ff) begin
                  x_in     = xorshift(acc_sum, MH_R);
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IDLE;   // middle word: no result
               end
            end
         end
         ST_TAIL: begin
            if (mul_done) begin
               x_in     = xorshift(acc_sum, MH_R);
               ph_in    = PH_FIRST;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (mul_done && out_free) begin
               hash_in      = fin_val;
               run_in       = run_ff ^ fin_val;
               rsp_data_in  = run_ff ^ fin_val;
               rsp_valid_in = 1'b1;
               ph_in        = PH_FIRST;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ph_in    = PH_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= PH_FIRST;
         seed_ff      <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         seed_ff      <= seed_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      len_ff      <= len_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---- assertions ----
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      ph_ff <= PH_LAST)
      else $error("multiplier phase out of range");

   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DISPATCH) |-> ph_ff == PH_FIRST)
      else $error("phase not cleared outside multiply states");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |->
         ($past(state_ff) == ST_FX2 || $past(state_ff) == ST_FIN))
      else $error("result raised outside a finishing state");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for murmur_value_and_bytes_hasher
// Drives fixed-value and byte-string beats, predicts each running hash in the
// bench and checks every result beat in order; random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
   import mvbh_pkg::*;

   // hash constants, kept local to the predictor
   localparam logic [63:0] K_FX1   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] K_FX2   = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] K_M     = 64'hc6a4a7935bd1e995;
   localparam logic [63:0] K_SEED  = 64'h00000000e17a1465;
   localparam int          SH_FX   = 33;
   localparam int          SH_MH   = 47;
   localparam logic [63:0] ONES    = 64'hffff_ffff_ffff_ffff;
   localparam logic [31:0] LEN_MAX = 32'hffff_ffff;

   localparam int SETTLE_CYCLES = 40;   // outlasts the longest string word
   localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
   localparam int PHASE_BEATS   = 315;
   localparam int N_PHASES      = 6;

   typedef struct packed {
      logic        op;
      logic        rst;
      logic [63:0] data;
      logic [31:0] len;
      logic        first;
      logic        last;
   } beat_type;

   typedef struct packed {
      beat_type    b;
      logic        chk;   // typed expectation valid
      logic [63:0] exp;
   } dir_row_type;

   // Directed table. Only the first two rows and the last row carry a typed
   // hash: with a zero running hash and zero seed, fmix64 of zero keeps it zero.
   localparam int N_DIR = 23;
   localparam dir_row_type DIR_TAB [0:N_DIR-1] = '{
      '{'{OP_VALUE,  1'b0, 64'h0,                 32'h0,        1'b0, 1'b0}, 1'b1, 64'h0},
      '{'{OP_VALUE,  1'b1, 64'h0,                 32'h0,        1'b0, 1'b0}, 1'b1, 64'h0},
      '{'{OP_VALUE,  1'b0, ONES,                  32'h0,        1'b0, 1'b0}, 1'b0, 64'h0},
      '{'{OP_VALUE,  1'b0, 64'h1,                 32'h0,        1'b0, 1'b0}, 1'b0, 64'h0},
      // flags and length ignored on a value
      '{'{OP_VALUE,  1'b0, 64'h8000000000000000,  LEN_MAX,      1'b1, 1'b1}, 1'b0, 64'h0},
      // zero length: data ignored
      '{'{OP_STRING, 1'b0, ONES,                  32'd0,        1'b1, 1'b1}, 1'b0, 64'h0},
      // length 8: last word is a full block
      '{'{OP_STRING, 1'b0, 64'h0706050403020100,  32'd8,        1'b1, 1'b1}, 1'b0, 64'h0},
      // one and seven tail bytes
      '{'{OP_STRING, 1'b0, ONES,                  32'd1,        1'b1, 1'b1}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, ONES,                  32'd7,        1'b1, 1'b1}, 1'b0, 64'h0},
      // two full blocks; length on the second word is ignored
      '{'{OP_STRING, 1'b0, 64'h1122334455667788,  32'd16,       1'b1, 1'b0}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, 64'h99aabbccddeeff00,  32'hdeadbeef, 1'b0, 1'b1}, 1'b0, 64'h0},
      // restart on a middle word
      '{'{OP_STRING, 1'b1, 64'h0123456789abcdef,  32'd13,       1'b1, 1'b0}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, 64'hfedcba9876543210,  32'd0,        1'b0, 1'b1}, 1'b0, 64'h0},
      // max length, ended early with a seven-byte tail
      '{'{OP_STRING, 1'b0, ONES,                  LEN_MAX,      1'b1, 1'b0}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, 64'h0,                 32'd0,        1'b0, 1'b0}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, ONES,                  32'd0,        1'b0, 1'b1}, 1'b0, 64'h0},
      // more words than the length needs
      '{'{OP_STRING, 1'b0, 64'h00000000a5a5a5a5,  32'd3,        1'b1, 1'b0}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, 64'h5a5a5a5a00000000,  32'd0,        1'b0, 1'b0}, 1'b0, 64'h0},
      // restart on a last word
      '{'{OP_STRING, 1'b1, 64'h0000000000c0ffee,  32'd0,        1'b0, 1'b1}, 1'b0, 64'h0},
      // words with no first word continue from the stored string state
      '{'{OP_STRING, 1'b0, 64'h13579bdf02468ace,  32'd0,        1'b0, 1'b1}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, 64'hcafef00d12345678,  LEN_MAX,      1'b0, 1'b0}, 1'b0, 64'h0},
      '{'{OP_STRING, 1'b0, 64'h8765432100000001,  32'd0,        1'b0, 1'b1}, 1'b0, 64'h0},
      // restart on a value, seed still zero
      '{'{OP_VALUE,  1'b1, 64'h0,                 32'h0,        1'b0, 1'b0}, 1'b1, 64'h0}
   };

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [WORD_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata  = '0;   // data_word, byte_length
   logic [TUSER_W-1:0]   req_tuser  = '0;   // opcode, restart, first_word
   logic                 req_tlast  = 1'b0; // last_word
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [WORD_W-1:0]    rsp_tdata;         // hash_out

   // predictor state
   logic [63:0] seed_shadow = '0;
   logic [63:0] run_hash    = '0;
   logic [63:0] str_hash    = '0;
   logic [31:0] str_len     = '0;

   logic [63:0] pending_hashes [$];
   int          error_count = 0;
   int          beats_sent  = 0;
   bit          calm        = 1'b0;  // no idling on either stream
   int          hold_asked  = 0;
   int          hold_done   = 0;
   int          hold_left   = 0;

   murmur_value_and_bytes_hasher u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("murmur_value_and_bytes_hasher regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] value_finalizer(input logic [63:0] x);
      logic [63:0] v;
      v = x ^ (x >> SH_FX);
      v = v * K_FX1;
      v = v ^ (v >> SH_FX);
      v = v * K_FX2;
      return v ^ (v >> SH_FX);
   endfunction

   function automatic logic [63:0] block_mix(input logic [63:0] h, input logic [63:0] k);
      logic [63:0] kk;
      kk = k * K_M;
      kk = kk ^ (kk >> SH_MH);
      kk = kk * K_M;
      return (h ^ kk) * K_M;
   endfunction

   // Advances the predicted state by one beat; returns 1 when a hash comes out.
   function automatic bit hash_step(input beat_type b, output logic [63:0] hash_out);
      logic [63:0] h;
      logic [2:0]  tail;
      hash_out = '0;
      if (b.rst)
         run_hash = seed_shadow;
      if (b.op == OP_VALUE) begin
         run_hash = run_hash ^ value_finalizer(b.data);
         hash_out = run_hash;
         return 1'b1;
      end
      if (b.first) begin
         str_len  = b.len;
         str_hash = K_SEED ^ ({32'b0, b.len} * K_M);
      end
      if (!b.last) begin
         str_hash = block_mix(str_hash, b.data);
         return 1'b0;
      end
      h    = str_hash;
      tail = str_len[2:0];
      if (tail != 3'd0) begin
         h = h ^ (b.data & ~(ONES << (8 * tail)));
         h = h * K_M;
      end else if (str_len != 32'd0) begin
         h = block_mix(h, b.data);
      end
      h        = h ^ (h >> SH_MH);
      h        = h * K_M;
      h        = h ^ (h >> SH_MH);
      str_hash = h;
      run_hash = run_hash ^ h;
      hash_out = run_hash;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- request side

   // Offers one beat and waits for it to be taken. valid stays high on return,
   // so the caller must offer the next beat or drop valid in the same step.
   task automatic offer_beat(input beat_type b, input bit typed,
                             input logic [63:0] typed_hash);
      logic [63:0]        h;
      logic [TUSER_W-1:0] user;
      if (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      user               = '0;
      user[USER_OPCODE]  = b.op;
      user[USER_RESTART] = b.rst;
      user[USER_FIRST]   = b.first;
      req_tvalid <= 1'b1;
      req_tdata  <= {b.len, b.data};
      req_tuser  <= user;
      req_tlast  <= b.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (hash_step(b, h))
         pending_hashes.push_back(typed ? typed_hash : h);
   endtask

   // Sender pause: nothing offered until all hashes are back and the block
   // has had time to finish a trailing middle word.
   task automatic drain_hashes();
      req_tvalid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      seed_shadow = value;
   endtask

   // One random burst: a value, a string run (mostly well formed), or a
   // stray word that continues the stored string state.
   task automatic random_burst();
      beat_type    b;
      int          pick;
      int          len_pick;
      int          nwords;
      logic [31:0] blen;
      pick = $urandom_range(99);
      if (pick < 30) begin
         b.op    = OP_VALUE;
         b.rst   = ($urandom_range(9) == 0);
         b.data  = {$urandom, $urandom};
         b.len   = $urandom;
         b.first = 1'($urandom_range(1));
         b.last  = 1'($urandom_range(1));
         offer_beat(b, 1'b0, '0);
      end else if (pick < 95) begin
         len_pick = $urandom_range(99);
         if (len_pick < 70)
            blen = $urandom_range(40);
         else if (len_pick < 90)
            blen = $urandom_range(64, 41);
         else
            blen = $urandom;
         if (blen == 0)
            nwords = 1;
         else if (blen <= 64)
            nwords = (blen + 7) / 8;
         else
            nwords = $urandom_range(5, 1);   // long lengths end early
         if (pick >= 85)
            nwords = $urandom_range(6, 1);   // word count off from length
         for (int w = 0; w < nwords; w++) begin
            b.op    = OP_STRING;
            b.rst   = (w == 0) ? ($urandom_range(9) == 0) : ($urandom_range(29) == 0);
            b.data  = {$urandom, $urandom};
            b.len   = (w == 0) ? blen : $urandom;
            b.first = (w == 0);
            b.last  = (w == nwords - 1);
            offer_beat(b, 1'b0, '0);
         end
      end else begin
         b.op    = OP_STRING;
         b.rst   = ($urandom_range(9) == 0);
         b.data  = {$urandom, $urandom};
         b.len   = $urandom;
         b.first = 1'b0;
         b.last  = 1'($urandom_range(1));
         offer_beat(b, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------- result side

   // Ready with random stalls; a requested hold-off parks it low for a long
   // stretch so the block backs up into its input.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= hold_asked;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hashes.size() == 0) begin
            $error("hash_out: beat with nothing expected, actual %h", rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== pending_hashes[0]) begin
               $error("hash_out mismatch: expected %h, actual %h",
                      pending_hashes[0], rsp_tdata);
               error_count++;
            end
            void'(pending_hashes.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [63:0] seeds [N_PHASES];
      int          phase_end;
      seeds[0] = ONES;
      seeds[1] = 64'h1;
      seeds[2] = {$urandom, $urandom};
      seeds[3] = 64'h8000_0000_0000_0000;
      seeds[4] = {$urandom, $urandom};
      seeds[5] = 64'h0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part runs on the reset seed
      for (int i = 0; i < N_DIR; i++)
         offer_beat(DIR_TAB[i].b, DIR_TAB[i].chk, DIR_TAB[i].exp);
      drain_hashes();

      for (int p = 0; p < N_PHASES; p++) begin
         write_seed(seeds[p]);
         calm = (p == 2);
         if (p == 3)
            hold_asked++;
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end)
            random_burst();
         drain_hashes();
      end

      if (error_count == 0)
         $display("murmur_value_and_bytes_hasher regression: pass");
      else
         $display("murmur_value_and_bytes_hasher regression: fail");
      $finish;
   end

endmodule
